>>> rtl/sra_pkg.sv
// types, constants and control store of the spectrum region activation block
package sra_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd4;

    // microprogram address width and step addresses
    localparam int unsigned UPC_W = 5;
    localparam logic [UPC_W-1:0] A_IDLE      = 5'd0;
    localparam logic [UPC_W-1:0] A_CHECK     = 5'd1;
    localparam logic [UPC_W-1:0] A_FRESH     = 5'd2;
    localparam logic [UPC_W-1:0] A_INIT_STEP = 5'd3;
    localparam logic [UPC_W-1:0] A_DIV_STEP  = 5'd4;
    localparam logic [UPC_W-1:0] A_SAVE_STEP = 5'd5;
    localparam logic [UPC_W-1:0] A_INIT_POS  = 5'd6;
    localparam logic [UPC_W-1:0] A_DIV_POS   = 5'd7;
    localparam logic [UPC_W-1:0] A_SAVE_POS  = 5'd8;
    localparam logic [UPC_W-1:0] A_EDGE      = 5'd9;
    localparam logic [UPC_W-1:0] A_OVL       = 5'd10;
    localparam logic [UPC_W-1:0] A_MUL       = 5'd11;
    localparam logic [UPC_W-1:0] A_ACC       = 5'd12;
    localparam logic [UPC_W-1:0] A_FRAME     = 5'd13;
    localparam logic [UPC_W-1:0] A_AREA      = 5'd14;
    localparam logic [UPC_W-1:0] A_INIT_FRAC = 5'd15;
    localparam logic [UPC_W-1:0] A_DIV_FRAC  = 5'd16;
    localparam logic [UPC_W-1:0] A_ROUND     = 5'd17;
    localparam logic [UPC_W-1:0] A_SAT       = 5'd18;
    localparam logic [UPC_W-1:0] A_ZERO      = 5'd19;
    localparam logic [UPC_W-1:0] A_EMIT      = 5'd20;
    localparam logic [UPC_W-1:0] A_HOLD      = 5'd21;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT_STEP,
        OP_DIV_STEP,
        OP_SAVE_STEP,
        OP_INIT_POS,
        OP_SAVE_POS,
        OP_EDGE,
        OP_OVL,
        OP_MUL,
        OP_ACC,
        OP_AREA,
        OP_INIT_FRAC,
        OP_ROUND,
        OP_SAT,
        OP_ZERO,
        OP_EMIT
    } op_t;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_POS_GE_N,
        C_FRESH,
        C_POS_ZERO,
        C_LOOP,
        C_NOT_LAST,
        C_AREA_EMPTY,
        C_NUM_GE_DEN,
        C_OUT_FREE
    } cond_t;

    // loop counter actions
    typedef enum logic [2:0] {
        CNT_HOLD,
        CNT_DEC,
        CNT_EDGE,
        CNT_POS,
        CNT_FRAC
    } cnt_op_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        cnt_op_t          cnt;
        logic [UPC_W-1:0] target;
    } uword_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic req;
        logic pos_ge_n;
        logic fresh;
        logic pos_zero;
        logic not_last;
        logic area_empty;
        logic num_ge_den;
        logic out_free;
    } status_t;

    // control store
    function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
        uword_t w;
        w = '{OP_NOP, C_ALWAYS, CNT_HOLD, A_IDLE};
        unique case (addr)
            A_IDLE:      w = '{OP_LOAD,      C_NO_REQ,     CNT_HOLD, A_IDLE};
            A_CHECK:     w = '{OP_NOP,       C_POS_GE_N,   CNT_HOLD, A_FRAME};
            A_FRESH:     w = '{OP_NOP,       C_FRESH,      CNT_HOLD, A_EDGE};
            A_INIT_STEP: w = '{OP_INIT_STEP, C_NEVER,      CNT_EDGE, A_IDLE};
            A_DIV_STEP:  w = '{OP_DIV_STEP,  C_LOOP,       CNT_DEC,  A_DIV_STEP};
            A_SAVE_STEP: w = '{OP_SAVE_STEP, C_POS_ZERO,   CNT_HOLD, A_EDGE};
            A_INIT_POS:  w = '{OP_INIT_POS,  C_NEVER,      CNT_POS,  A_IDLE};
            A_DIV_POS:   w = '{OP_DIV_STEP,  C_LOOP,       CNT_DEC,  A_DIV_POS};
            A_SAVE_POS:  w = '{OP_SAVE_POS,  C_NEVER,      CNT_HOLD, A_IDLE};
            A_EDGE:      w = '{OP_EDGE,      C_NEVER,      CNT_HOLD, A_IDLE};
            A_OVL:       w = '{OP_OVL,       C_NEVER,      CNT_HOLD, A_IDLE};
            A_MUL:       w = '{OP_MUL,       C_NEVER,      CNT_HOLD, A_IDLE};
            A_ACC:       w = '{OP_ACC,       C_NEVER,      CNT_HOLD, A_IDLE};
            A_FRAME:     w = '{OP_NOP,       C_NOT_LAST,   CNT_HOLD, A_IDLE};
            A_AREA:      w = '{OP_AREA,      C_AREA_EMPTY, CNT_HOLD, A_ZERO};
            A_INIT_FRAC: w = '{OP_INIT_FRAC, C_NUM_GE_DEN, CNT_FRAC, A_SAT};
            A_DIV_FRAC:  w = '{OP_DIV_STEP,  C_LOOP,       CNT_DEC,  A_DIV_FRAC};
            A_ROUND:     w = '{OP_ROUND,     C_ALWAYS,     CNT_HOLD, A_EMIT};
            A_SAT:       w = '{OP_SAT,       C_ALWAYS,     CNT_HOLD, A_EMIT};
            A_ZERO:      w = '{OP_ZERO,      C_NEVER,      CNT_HOLD, A_IDLE};
            A_EMIT:      w = '{OP_EMIT,      C_OUT_FREE,   CNT_HOLD, A_IDLE};
            A_HOLD:      w = '{OP_NOP,       C_ALWAYS,     CNT_HOLD, A_EMIT};
            default:     w = '{OP_NOP,       C_ALWAYS,     CNT_HOLD, A_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/sra_ctrl.sv
// microcode sequencer: step counter, control store and loop counter
module sra_ctrl #(
    parameter int unsigned EDGE_STEPS = 17,
    parameter int unsigned POS_STEPS  = 25,
    parameter int unsigned FRAC_STEPS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sra_pkg::status_t  status,
    output sra_pkg::op_t      op
);

    // position division is the longest loop
    localparam int unsigned CNT_W = $clog2(POS_STEPS + 1);

    logic [sra_pkg::UPC_W-1:0] pc_reg, pc_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    sra_pkg::uword_t           word;
    logic                      take;

    assign word = sra_pkg::ucode(pc_reg);
    assign op   = word.op;

    always_comb begin
        unique case (word.cond)
            sra_pkg::C_NEVER:      take = 1'b0;
            sra_pkg::C_ALWAYS:     take = 1'b1;
            sra_pkg::C_NO_REQ:     take = !status.req;
            sra_pkg::C_POS_GE_N:   take = status.pos_ge_n;
            sra_pkg::C_FRESH:      take = status.fresh;
            sra_pkg::C_POS_ZERO:   take = status.pos_zero;
            sra_pkg::C_LOOP:       take = (cnt_reg != CNT_W'(1));
            sra_pkg::C_NOT_LAST:   take = status.not_last;
            sra_pkg::C_AREA_EMPTY: take = status.area_empty;
            sra_pkg::C_NUM_GE_DEN: take = status.num_ge_den;
            sra_pkg::C_OUT_FREE:   take = status.out_free;
            default:               take = 1'b0;
        endcase
        pc_next = take ? word.target : pc_reg + sra_pkg::UPC_W'(1);
    end

    always_comb begin
        unique case (word.cnt)
            sra_pkg::CNT_HOLD: cnt_next = cnt_reg;
            sra_pkg::CNT_DEC:  cnt_next = cnt_reg - CNT_W'(1);
            sra_pkg::CNT_EDGE: cnt_next = CNT_W'(EDGE_STEPS);
            sra_pkg::CNT_POS:  cnt_next = CNT_W'(POS_STEPS);
            sra_pkg::CNT_FRAC: cnt_next = CNT_W'(FRAC_STEPS);
            default:           cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= sra_pkg::A_IDLE;
            cnt_reg <= '0;
        end else begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/spectrum_region_activation.sv
// top level of the spectrum region activation block: registers, datapath, ports
//
// Measures how much of a rectangular region of a spectrum display the bars
// cover. One bar magnitude is taken per request, in bar order; bar i spans
// floor(i*ONE/N) to floor((i+1)*ONE/N) across and 0 to its magnitude up. The
// overlap area of each bar with the region is summed exactly, and on the
// request flagged tlast the sum is divided by the region area, rounded to
// nearest, and sent out together with a flag that says whether it differs
// from the previous frame's value. A bar is finished before the next request
// is taken; the bar edges are stepped incrementally and the overlap product
// goes through one shared multiplier. After reset or a write of bar_count the
// next bar also runs the step width division, and a division for its left
// edge when that write fell mid-frame. The last bar of a frame adds the area
// product and a restoring divide of one quotient bit per cycle, which is
// skipped when the region is empty or fully covered, plus any wait for the
// result register to be taken. A new request is taken while an earlier
// result is still waiting on m_tready.
module spectrum_region_activation #(
    parameter int unsigned MAX_BARS  = 256,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [((FRAC_BITS+1 > $clog2(MAX_BARS+1)) ? FRAC_BITS+1
                  : $clog2(MAX_BARS+1))-1:0] cfg_data,
    // bar input
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [((FRAC_BITS+8)/8)*8-1:0] s_tdata,  // bar_magnitude
    input  logic                        s_tlast,     // last_bar
    // activation output
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [((FRAC_BITS+8)/8)*8-1:0] m_tdata,  // activation
    output logic                        m_tuser      // activation_changed
);

    localparam int unsigned EDGE_W = FRAC_BITS + 1;
    localparam int unsigned DATA_W = ((FRAC_BITS + 8) / 8) * 8;
    localparam int unsigned POS_W  = $clog2(MAX_BARS + 1);
    localparam int unsigned PROD_W = 2 * FRAC_BITS + 1;
    localparam int unsigned REM_W  = PROD_W + 1;
    localparam int unsigned DVD_W  = POS_W + FRAC_BITS;
    localparam int unsigned CFG_W  = (EDGE_W > POS_W) ? EDGE_W : POS_W;
    localparam int unsigned CSRC_W = (CFG_W < 16) ? CFG_W : 16;

    localparam logic [EDGE_W-1:0] ONE       = EDGE_W'(1) << FRAC_BITS;
    localparam logic [EDGE_W-1:0] LO_RST    = EDGE_W'(((2 ** FRAC_BITS) * 17 + 20) / 40);
    localparam logic [EDGE_W-1:0] HI_RST    = EDGE_W'(((2 ** FRAC_BITS) * 23 + 20) / 40);
    localparam logic [POS_W-1:0]  MAX_N     = POS_W'(MAX_BARS);
    localparam logic [POS_W-1:0]  COUNT_RST = POS_W'((MAX_BARS < 32) ? MAX_BARS : 32);

    function automatic logic [EDGE_W-1:0] sat_one(input logic [EDGE_W-1:0] v);
        return (v > ONE) ? ONE : v;
    endfunction

    // configuration registers
    logic [EDGE_W-1:0] left_reg, left_next;
    logic [EDGE_W-1:0] right_reg, right_next;
    logic [EDGE_W-1:0] bottom_reg, bottom_next;
    logic [EDGE_W-1:0] top_reg, top_next;
    logic [POS_W-1:0]  count_reg, count_next;

    // frame state
    logic              stale_reg, stale_next;   // step width needs recomputing
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [PROD_W-1:0] sum_reg, sum_next;
    logic [EDGE_W-1:0] last_act_reg, last_act_next;

    // captured request
    logic [EDGE_W-1:0] mag_reg, mag_next;
    logic              last_reg, last_next;

    // bar edge stepping: edge = q0 * i + carries of r0 / n
    logic [EDGE_W-1:0] q0_reg, q0_next;
    logic [POS_W-1:0]  r0_reg, r0_next;
    logic [EDGE_W-1:0] e0_reg, e0_next;
    logic [POS_W-1:0]  erem_reg, erem_next;
    logic [EDGE_W-1:0] e1_reg, e1_next;

    // overlaps and product
    logic [EDGE_W-1:0] h_reg, h_next;
    logic [EDGE_W-1:0] v_reg, v_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    // shared restoring divider
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [PROD_W-1:0] den_reg, den_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;

    // result register
    logic              m_valid_reg, m_valid_next;
    logic [EDGE_W-1:0] act_reg, act_next;
    logic              chg_reg, chg_next;

    sra_pkg::op_t     op;
    sra_pkg::status_t status;

    logic [EDGE_W-1:0]   left_s, right_s, bottom_s, top_s;
    logic [POS_W-1:0]    n_eff;
    logic [CSRC_W-1:0]   count_src;
    logic [EDGE_W-1:0]   dx, dy;
    logic                area_empty;
    logic [EDGE_W-1:0]   mul_a, mul_b;
    logic [2*EDGE_W-1:0] mul_full;
    logic [REM_W-1:0]    rem_sh, den_ext, div_diff;
    logic                div_ge;
    logic [POS_W:0]      rsum;
    logic                carry;
    logic [EDGE_W-1:0]   vt, hi, lo;
    logic                in_fire, out_free, emit;

    assign cfg_ready = 1'b1;
    assign s_tready  = (op == sra_pkg::OP_LOAD);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign emit      = (op == sra_pkg::OP_EMIT) && out_free;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_W'(act_reg);
    assign m_tuser  = chg_reg;

    // bar count write keeps 16 bits, a count past MAX_BARS is stored as MAX_BARS
    assign count_src = cfg_data[CSRC_W-1:0];

    // edges above one are clamped; bar count out of range is clamped to 1..MAX_BARS
    assign left_s   = sat_one(left_reg);
    assign right_s  = sat_one(right_reg);
    assign bottom_s = sat_one(bottom_reg);
    assign top_s    = sat_one(top_reg);
    assign n_eff    = (count_reg == '0) ? POS_W'(1) :
                      (count_reg > MAX_N) ? MAX_N : count_reg;

    assign dx         = right_s - left_s;
    assign dy         = top_s - bottom_s;
    assign area_empty = !((right_s > left_s) && (top_s > bottom_s));

    // one multiplier for the bar overlap product and the region area
    assign mul_a    = (op == sra_pkg::OP_AREA) ? dx : h_reg;
    assign mul_b    = (op == sra_pkg::OP_AREA) ? dy : v_reg;
    assign mul_full = mul_a * mul_b;

    // one quotient bit per cycle, dividend bits shift in from the top of dvd_reg
    assign rem_sh   = {rem_reg[REM_W-2:0], dvd_reg[DVD_W-1]};
    assign den_ext  = {1'b0, den_reg};
    assign div_ge   = (rem_sh >= den_ext);
    assign div_diff = rem_sh - den_ext;

    // next bar edge from the stepped remainder
    assign rsum  = {1'b0, erem_reg} + {1'b0, r0_reg};
    assign carry = (rsum >= {1'b0, n_eff});

    // vertical overlap with a bar that spans 0..magnitude
    assign vt = (mag_reg < top_s) ? mag_reg : top_s;
    // horizontal overlap with the bar between e0 and e1
    assign hi = (e1_reg < right_s) ? e1_reg : right_s;
    assign lo = (e0_reg > left_s) ? e0_reg : left_s;

    assign status.req        = s_tvalid;
    assign status.pos_ge_n   = (pos_reg >= n_eff);
    assign status.fresh      = !stale_reg;
    assign status.pos_zero   = (pos_reg == '0);
    assign status.not_last   = !last_reg;
    assign status.area_empty = area_empty;
    assign status.num_ge_den = ({1'b0, sum_reg} >= {1'b0, prod_reg});
    assign status.out_free   = out_free;

    sra_ctrl #(
        .EDGE_STEPS (EDGE_W),
        .POS_STEPS  (DVD_W),
        .FRAC_STEPS (FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .op      (op)
    );

    always_comb begin
        left_next     = left_reg;
        right_next    = right_reg;
        bottom_next   = bottom_reg;
        top_next      = top_reg;
        count_next    = count_reg;
        stale_next    = stale_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        last_act_next = last_act_reg;
        mag_next      = mag_reg;
        last_next     = last_reg;
        q0_next       = q0_reg;
        r0_next       = r0_reg;
        e0_next       = e0_reg;
        erem_next     = erem_reg;
        e1_next       = e1_reg;
        h_next        = h_reg;
        v_next        = v_reg;
        prod_next     = prod_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        dvd_next      = dvd_reg;
        quo_next      = quo_reg;
        m_valid_next  = m_valid_reg;
        act_next      = act_reg;
        chg_next      = chg_reg;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sra_pkg::REG_LEFT:   left_next   = cfg_data[EDGE_W-1:0];
                sra_pkg::REG_RIGHT:  right_next  = cfg_data[EDGE_W-1:0];
                sra_pkg::REG_BOTTOM: bottom_next = cfg_data[EDGE_W-1:0];
                sra_pkg::REG_TOP:    top_next    = cfg_data[EDGE_W-1:0];
                sra_pkg::REG_COUNT: begin
                    count_next = (count_src > CSRC_W'(MAX_BARS)) ? MAX_N
                                                                 : POS_W'(count_src);
                    stale_next = 1'b1;
                end
                default: ;
            endcase
        end

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (op)
            sra_pkg::OP_LOAD: begin
                if (in_fire) begin
                    mag_next  = s_tdata[EDGE_W-1:0];
                    last_next = s_tlast;
                end
            end
            // step width ONE / n
            sra_pkg::OP_INIT_STEP: begin
                rem_next = '0;
                den_next = PROD_W'(n_eff);
                dvd_next = DVD_W'(ONE) << (POS_W - 1);
                quo_next = '0;
            end
            sra_pkg::OP_DIV_STEP: begin
                rem_next = div_ge ? div_diff : rem_sh;
                quo_next = {quo_reg[DVD_W-2:0], div_ge};
                dvd_next = dvd_reg << 1;
            end
            sra_pkg::OP_SAVE_STEP: begin
                q0_next    = quo_reg[EDGE_W-1:0];
                r0_next    = rem_reg[POS_W-1:0];
                stale_next = 1'b0;
                e0_next    = '0;
                erem_next  = '0;
            end
            // bar count changed mid-frame: left edge of this bar from scratch
            sra_pkg::OP_INIT_POS: begin
                rem_next = '0;
                den_next = PROD_W'(n_eff);
                dvd_next = {pos_reg, {FRAC_BITS{1'b0}}};
                quo_next = '0;
            end
            sra_pkg::OP_SAVE_POS: begin
                e0_next   = quo_reg[EDGE_W-1:0];
                erem_next = rem_reg[POS_W-1:0];
            end
            sra_pkg::OP_EDGE: begin
                e1_next   = e0_reg + q0_reg + EDGE_W'(carry);
                erem_next = carry ? POS_W'(rsum - {1'b0, n_eff}) : rsum[POS_W-1:0];
                v_next    = (vt > bottom_s) ? vt - bottom_s : '0;
            end
            sra_pkg::OP_OVL: begin
                h_next = (hi > lo) ? hi - lo : '0;
            end
            sra_pkg::OP_MUL, sra_pkg::OP_AREA: begin
                prod_next = mul_full[PROD_W-1:0];
            end
            sra_pkg::OP_ACC: begin
                sum_next = sum_reg + prod_reg;
                pos_next = pos_reg + POS_W'(1);
                e0_next  = e1_reg;
            end
            sra_pkg::OP_INIT_FRAC: begin
                rem_next = REM_W'(sum_reg);
                den_next = prod_reg;
                dvd_next = '0;
                quo_next = '0;
            end
            // round to nearest, ties up
            sra_pkg::OP_ROUND: begin
                quo_next = quo_reg + DVD_W'(div_ge);
            end
            sra_pkg::OP_SAT: begin
                quo_next = DVD_W'(ONE);
            end
            sra_pkg::OP_ZERO: begin
                quo_next = '0;
            end
            sra_pkg::OP_EMIT: begin
                if (emit) begin
                    m_valid_next  = 1'b1;
                    act_next      = quo_reg[EDGE_W-1:0];
                    chg_next      = (quo_reg[EDGE_W-1:0] != last_act_reg);
                    last_act_next = quo_reg[EDGE_W-1:0];
                    sum_next      = '0;
                    pos_next      = '0;
                    e0_next       = '0;
                    erem_next     = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg     <= LO_RST;
            right_reg    <= HI_RST;
            bottom_reg   <= LO_RST;
            top_reg      <= HI_RST;
            count_reg    <= COUNT_RST;
            stale_reg    <= 1'b1;
            pos_reg      <= '0;
            sum_reg      <= '0;
            last_act_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            left_reg     <= left_next;
            right_reg    <= right_next;
            bottom_reg   <= bottom_next;
            top_reg      <= top_next;
            count_reg    <= count_next;
            stale_reg    <= stale_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            last_act_reg <= last_act_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        last_reg <= last_next;
        q0_reg   <= q0_next;
        r0_reg   <= r0_next;
        e0_reg   <= e0_next;
        erem_reg <= erem_next;
        e1_reg   <= e1_next;
        h_reg    <= h_next;
        v_reg    <= v_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        act_reg  <= act_next;
        chg_reg  <= chg_next;
    end

    // one request in flight at a time
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while a bar is in progress");

    // a result only follows a bar flagged last
    a_emit_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> last_reg)
        else $error("result sent for a bar not marked last");

    // bar position stays within the largest bar count
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= MAX_N)
        else $error("bar position overran");

    // stepped bar edges are ordered and within the display
    a_edge_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == sra_pkg::OP_OVL) |-> (e1_reg >= e0_reg) && (e1_reg <= ONE))
        else $error("bar edges out of order");

    // accumulation never wraps
    a_sum_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == sra_pkg::OP_ACC) |=> (sum_reg >= $past(sum_reg)))
        else $error("covered sum wrapped");

endmodule

>>> tb/activation_monitor.sv
`timescale 1ns / 1ps
// channel monitor that predicts and checks the activation results of the region block
module activation_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // bar_magnitude
    input  logic        s_tlast,   // last_bar
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // activation
    input  logic        m_tuser,   // activation_changed
    output int          fail_count,
    output int          pending_count
);

    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned BAR_LIMIT = 256;
    localparam logic [63:0] UNIT      = 64'd1 << FRAC_W;
    localparam logic [16:0] UNIT_Q    = 17'h10000;

    typedef struct packed {
        logic [16:0] activation;
        logic        changed;
    } activation_t;

    logic [16:0] left_edge, right_edge, bottom_edge, top_edge;
    logic [15:0] bars_per_frame;
    logic [63:0] covered_area;
    logic [63:0] bar_index;
    logic [16:0] prev_activation;
    activation_t expected_activations[$];

    function automatic logic [63:0] clamp_unit(input logic [16:0] v);
        return ({47'd0, v} > UNIT) ? UNIT : {47'd0, v};
    endfunction

    function automatic logic [63:0] span_overlap(input logic [63:0] s1, input logic [63:0] e1,
                                                 input logic [63:0] s2, input logic [63:0] e2);
        logic [63:0] hi, lo;
        hi = (e1 < e2) ? e1 : e2;
        lo = (s1 > s2) ? s1 : s2;
        return (hi > lo) ? hi - lo : 64'd0;
    endfunction

    // restoring divide of one quotient bit per step, rounded half up
    function automatic logic [16:0] quantize_ratio(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q, rem;
        if (num >= den) return UNIT_Q;
        q = 64'd0;
        rem = num;
        for (int k = 0; k < FRAC_W; k++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q[0] = 1'b1;
            end
        end
        if ((rem << 1) >= den) q = q + 64'd1;
        return (q > UNIT) ? UNIT_Q : q[16:0];
    endfunction

    task automatic absorb_bar(input logic [16:0] magnitude, input logic last);
        logic [63:0] lo_x, hi_x, lo_y, hi_y, n, e0, e1;
        logic [16:0] act;
        activation_t res;
        lo_x = clamp_unit(left_edge);
        hi_x = clamp_unit(right_edge);
        lo_y = clamp_unit(bottom_edge);
        hi_y = clamp_unit(top_edge);
        if (bars_per_frame == 16'd0) n = 64'd1;
        else if (bars_per_frame > BAR_LIMIT) n = 64'(BAR_LIMIT);
        else n = {48'd0, bars_per_frame};
        if (bar_index < n) begin
            e0 = (bar_index * UNIT) / n;
            e1 = ((bar_index + 64'd1) * UNIT) / n;
            covered_area = covered_area + span_overlap(lo_x, hi_x, e0, e1)
                         * span_overlap(lo_y, hi_y, 64'd0, {47'd0, magnitude});
            bar_index = bar_index + 64'd1;
        end
        if (last) begin
            if (hi_x > lo_x && hi_y > lo_y)
                act = quantize_ratio(covered_area, (hi_x - lo_x) * (hi_y - lo_y));
            else
                act = 17'd0;
            res.activation = act;
            res.changed = (act != prev_activation);
            expected_activations.push_back(res);
            prev_activation = act;
            covered_area = 64'd0;
            bar_index = 64'd0;
        end
    endtask

    task automatic check_activation();
        activation_t res;
        if (expected_activations.size() == 0) begin
            if (fail_count < 10)
                $display("unexpected activation %h changed %b", m_tdata, m_tuser);
            fail_count++;
        end else begin
            res = expected_activations.pop_front();
            if (m_tdata !== {7'd0, res.activation} || m_tuser !== res.changed) begin
                if (fail_count < 10)
                    $display("activation mismatch: expected %h/%b got %h/%b",
                             {7'd0, res.activation}, res.changed, m_tdata, m_tuser);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            left_edge = 17'd27853;
            right_edge = 17'd37683;
            bottom_edge = 17'd27853;
            top_edge = 17'd37683;
            bars_per_frame = 16'd32;
            covered_area = 64'd0;
            bar_index = 64'd0;
            prev_activation = 17'd0;
            expected_activations.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) check_activation();
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sra_pkg::REG_LEFT:   left_edge = cfg_data;
                    sra_pkg::REG_RIGHT:  right_edge = cfg_data;
                    sra_pkg::REG_BOTTOM: bottom_edge = cfg_data;
                    sra_pkg::REG_TOP:    top_edge = cfg_data;
                    sra_pkg::REG_COUNT:  bars_per_frame = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) absorb_bar(s_tdata[16:0], s_tlast);
        end
        pending_count = expected_activations.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, stimulus and verdict for the spectrum region activation block
module tb;

    localparam int unsigned SETTLE_CYCLES = 200;   // covers rate division plus final divide
    localparam int unsigned RANDOM_BARS   = 1200;
    localparam int unsigned STALL_AFTER   = 400;   // bar count that arms the long sink stall
    localparam int unsigned STALL_CYCLES  = 600;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;    // bar_magnitude
    logic        s_tlast = 1'b0;  // last_bar
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // activation
    logic        m_tuser;         // activation_changed

    int fail_count;
    int pending_count;
    int unsigned bars_sent = 0;
    int unsigned current_bars = 32;
    bit quiet_sender = 1'b0;
    bit quiet_receiver = 1'b0;
    bit stall_armed = 1'b0;
    bit stall_done = 1'b0;

    spectrum_region_activation DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    activation_monitor u_monitor (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_length(input bit quiet);
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [16:0] pick_magnitude();
        case ($urandom_range(0, 9))
            0:       return 17'd0;
            1:       return 17'h10000;
            2:       return 17'($urandom_range(65537, 131071));
            3, 4:    return 17'($urandom);
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic int unsigned pick_bar_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return $urandom_range(1, 12);
        if (roll < 80) return $urandom_range(13, 40);
        if (roll < 88) return $urandom_range(0, 2);
        if (roll < 95) return $urandom_range(200, 256);
        return $urandom_range(257, 511);
    endfunction

    // bars per frame as the block uses it
    function automatic int unsigned frame_span(input int unsigned count);
        if (count == 0) return 1;
        return (count > 256) ? 256 : count;
    endfunction

    task automatic pick_span(output logic [16:0] lo, output logic [16:0] hi);
        int unsigned a, b;
        case ($urandom_range(0, 9))
            0: begin
                lo = 17'd0;
                hi = 17'h10000;
            end
            1: begin
                // full width values, may be empty or past one
                lo = 17'($urandom);
                hi = 17'($urandom);
            end
            2: begin
                lo = 17'($urandom_range(0, 65536));
                hi = lo;
            end
            3: begin
                lo = 17'($urandom_range(0, 65000));
                hi = lo + 17'($urandom_range(1, 300));
            end
            default: begin
                a = $urandom_range(0, 65536);
                b = $urandom_range(0, 65536);
                lo = 17'((a < b) ? a : b);
                hi = 17'((a < b) ? b : a);
            end
        endcase
    endtask

    // one bar request; valid is left high so the next request can follow at once
    task automatic send_bar(input logic [16:0] magnitude, input bit last);
        int gap;
        gap = idle_length(quiet_sender);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, magnitude};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bars_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // writes the registers selected by mask, bit order as the register indexes
    task automatic load_region(input logic [4:0] mask, input logic [16:0] l, input logic [16:0] r,
                               input logic [16:0] b, input logic [16:0] t,
                               input int unsigned count);
        if (mask[0]) write_reg(sra_pkg::REG_LEFT, l);
        if (mask[1]) write_reg(sra_pkg::REG_RIGHT, r);
        if (mask[2]) write_reg(sra_pkg::REG_BOTTOM, b);
        if (mask[3]) write_reg(sra_pkg::REG_TOP, t);
        if (mask[4]) begin
            write_reg(sra_pkg::REG_COUNT, 17'(count));
            current_bars = count;
        end
        cfg_valid <= 1'b0;
    endtask

    // stop offering, let every result come out and the block go quiet
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic send_frame(input int unsigned span);
        int unsigned len;
        int roll;
        bit closed;
        roll = $urandom_range(0, 19);
        closed = 1'b1;
        if (roll < 15) len = span;
        else if (roll < 17) len = $urandom_range(1, span);
        else if (roll < 19) len = span + $urandom_range(1, 4);
        else begin
            // broken frame, runs on into the next one
            len = $urandom_range(1, span);
            closed = 1'b0;
        end
        for (int unsigned i = 0; i < len; i++)
            send_bar(pick_magnitude(), closed && (i == len - 1));
    endtask

    // result sink with random back pressure and one long hold-off
    initial begin : result_sink
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall_armed && !stall_done) begin
                stall_done = 1'b1;
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge aclk);
            end
            gap = idle_length(quiet_receiver);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    initial begin : stimulus
        int unsigned random_base, count, frames;
        logic [16:0] l, r, b, t;
        logic [4:0] mask;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset region, frame ends early: no bar reaches the region
        send_bar(17'h10000, 1'b0);
        send_bar(17'h10000, 1'b1);
        drain_and_settle();

        // whole display as region, four bars
        load_region(5'h1F, 17'd0, 17'h10000, 17'd0, 17'h10000, 4);
        repeat (3) send_bar(17'h10000, 1'b0);
        send_bar(17'h10000, 1'b1);
        send_bar(17'd0, 1'b0);
        send_bar(17'h1FFFF, 1'b0);
        send_bar(17'h08000, 1'b0);
        send_bar(17'd1, 1'b1);
        // too many bars in one frame
        repeat (5) send_bar(17'h0C000, 1'b0);
        send_bar(17'h10000, 1'b1);
        drain_and_settle();

        // left edge past one, right at zero: empty region, count zero used as one
        load_region(5'h1F, 17'h186A0, 17'd0, 17'd0, 17'h10000, 0);
        send_bar(17'h04000, 1'b0);
        send_bar(17'h0FFFF, 1'b1);
        drain_and_settle();

        // both side edges saturate to one, count above the bar limit
        load_region(5'h1F, 17'h1FFFF, 17'h1FFFF, 17'h08000, 17'h1FFFF, 511);
        send_bar(17'h10000, 1'b1);
        drain_and_settle();

        // bottom above top
        load_region(5'h1F, 17'h04000, 17'h0C000, 17'h0C000, 17'h04000, 2);
        send_bar(17'h10000, 1'b0);
        send_bar(17'h10000, 1'b1);

        random_base = bars_sent;
        while (bars_sent - random_base < RANDOM_BARS) begin
            drain_and_settle();
            quiet_sender = ($urandom_range(0, 3) == 0);
            quiet_receiver = ($urandom_range(0, 3) == 0);
            pick_span(l, r);
            pick_span(b, t);
            count = pick_bar_count();
            mask = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'h1F;
            load_region(mask, l, r, b, t, count);
            frames = (frame_span(current_bars) > 40) ? $urandom_range(1, 2)
                                                     : $urandom_range(3, 10);
            repeat (frames) begin
                send_frame(frame_span(current_bars));
                if (bars_sent >= STALL_AFTER) stall_armed = 1'b1;
            end
            // sometimes leave a frame open across the next register writes
            if ($urandom_range(0, 6) == 0)
                repeat ($urandom_range(1, 3)) send_bar(pick_magnitude(), 1'b0);
        end

        drain_and_settle();
        if (fail_count == 0 && pending_count == 0)
            $display("[spectrum_region_activation] OK");
        else
            $display("[spectrum_region_activation] ERROR");
        $finish;
    end

    initial begin : watchdog
        #(64'd20_000_000);
        $display("[spectrum_region_activation] ERROR");
        $finish;
    end

endmodule
